@@ rtl/cbhp_pkg.sv @@
// Package with the types and constants shared by the canonical block header parser.
package cbhp_pkg;

	localparam int unsigned SDNV_MAX_BYTES = 10;
	localparam int unsigned BYTE_W         = 8;
	localparam int unsigned SIZE_W         = 32;
	localparam int unsigned VALUE_W        = 64;
	localparam int unsigned GROUP_W        = 7;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_ERROR  = 2'd2
	} result_kind_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_BUF_SMALL = 3'd1,
		ERR_FLAGS_BAD = 3'd2,
		ERR_LEN_BAD   = 3'd3,
		ERR_LEN_BIG   = 3'd4
	} error_code_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_FLAGS = 2'd1,
		PH_LEN   = 2'd2,
		PH_DATA  = 2'd3
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] in_byte;
		logic              start_req;
		logic [SIZE_W-1:0] buffer_size;
	} in_item_t;

	typedef struct packed {
		result_kind_t       result_kind;
		logic [BYTE_W-1:0]  block_type;
		logic [VALUE_W-1:0] block_flags;
		logic [SIZE_W-1:0]  data_length;
		logic [BYTE_W-1:0]  out_byte;
		logic               last;
		logic [SIZE_W-1:0]  bytes_consumed;
		error_code_t        error_code;
	} out_item_t;

endpackage

@@ rtl/canonical_block_header_parser_unit.sv @@
// Top level of the canonical block header parser: byte-serial SDNV header decode and data pass.
//
// The block takes one byte of a serialized canonical block per input transaction on
// in_valid/in_ready with payload in_data. A byte with start_req set begins a new block
// (aborting any block in progress) and latches buffer_size. The block decodes the type
// byte, the flags SDNV and the length SDNV, then gives one header result, then one data
// result per data byte, the last one marked with last and the total byte count. Every
// error gives one error result with last set, and the block goes back to waiting for a
// start byte. Bytes outside a block give no result.
// Each byte goes into an input register, is decoded by one pass of logic against the
// parser state, and its result lands in the output register; one byte can be accepted in
// every cycle while the receiver does not stall.
// The rate is set by the single state update per byte (SDNV shift-accumulate, counters).
// When the receiver stalls, the result register holds and the input register fills;
// in_ready falls only when both are full. Reset clears both valid flags and returns the
// parser to idle; no clearing pass is needed.
module canonical_block_header_parser_unit #(
	parameter int unsigned SdnvMaxBytes = cbhp_pkg::SDNV_MAX_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cbhp_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output cbhp_pkg::out_item_t out_data
);

	localparam int unsigned CntW = $clog2(SdnvMaxBytes + 1);
	localparam int unsigned VW   = cbhp_pkg::VALUE_W;
	localparam int unsigned SW   = cbhp_pkg::SIZE_W;
	localparam int unsigned BW   = cbhp_pkg::BYTE_W;
	localparam int unsigned GW   = cbhp_pkg::GROUP_W;

	logic                valid_s1;
	cbhp_pkg::in_item_t  item_s1;
	logic                out_valid_q;
	cbhp_pkg::out_item_t out_data_q;

	cbhp_pkg::phase_t phase_q, phase_d;
	logic [BW-1:0]    type_q, type_d;
	logic [VW-1:0]    flags_q, flags_d;
	logic [VW-1:0]    accum_q, accum_d;
	logic [CntW-1:0]  count_q, count_d;
	logic [SW-1:0]    remaining_q, remaining_d;
	logic [SW-1:0]    data_left_q, data_left_d;
	logic [SW-1:0]    consumed_q, consumed_d;

	logic                advance;
	logic                fire;
	logic                res_vld;
	cbhp_pkg::out_item_t res;

	logic            buf_small;
	logic            cont;
	logic            sdnv_bad;
	logic [VW-1:0]   accum_nx;
	logic [CntW-1:0] cnt_inc;
	logic [SW-1:0]   rem_dec;
	logic [SW-1:0]   cons_inc;
	logic            len_big;
	logic            data_end;

	assign advance  = !out_valid_q || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	assign buf_small = (item_s1.buffer_size[SW-1:1] == '0);
	assign cont      = item_s1.in_byte[BW-1];
	assign accum_nx  = {accum_q[VW-GW-1:0], item_s1.in_byte[GW-1:0]};
	assign cnt_inc   = count_q + CntW'(1);
	assign rem_dec   = remaining_q - SW'(1);
	assign cons_inc  = consumed_q + SW'(1);
	assign sdnv_bad  = (accum_q[VW-1:VW-GW] != '0)
		|| (cont && ((cnt_inc >= CntW'(SdnvMaxBytes)) || (rem_dec == '0)));
	assign len_big   = (accum_nx > {{(VW-SW){1'b0}}, rem_dec});
	assign data_end  = (data_left_q == SW'(1));

	always_comb begin
		phase_d = phase_q;
		if (fire) begin
			if (item_s1.start_req) begin
				phase_d = buf_small ? cbhp_pkg::PH_IDLE : cbhp_pkg::PH_FLAGS;
			end else begin
				unique case (phase_q)
					cbhp_pkg::PH_IDLE: begin
						phase_d = cbhp_pkg::PH_IDLE;
					end
					cbhp_pkg::PH_FLAGS: begin
						priority if (sdnv_bad) phase_d = cbhp_pkg::PH_IDLE;
						else if (cont) phase_d = cbhp_pkg::PH_FLAGS;
						else if (rem_dec == '0) phase_d = cbhp_pkg::PH_IDLE;
						else phase_d = cbhp_pkg::PH_LEN;
					end
					cbhp_pkg::PH_LEN: begin
						priority if (sdnv_bad) phase_d = cbhp_pkg::PH_IDLE;
						else if (cont) phase_d = cbhp_pkg::PH_LEN;
						else if (len_big) phase_d = cbhp_pkg::PH_IDLE;
						else if (accum_nx == '0) phase_d = cbhp_pkg::PH_IDLE;
						else phase_d = cbhp_pkg::PH_DATA;
					end
					cbhp_pkg::PH_DATA: begin
						phase_d = data_end ? cbhp_pkg::PH_IDLE : cbhp_pkg::PH_DATA;
					end
					default: begin
						phase_d = cbhp_pkg::PH_IDLE;
					end
				endcase
			end
		end
	end

	always_comb begin
		type_d      = type_q;
		flags_d     = flags_q;
		accum_d     = accum_q;
		count_d     = count_q;
		remaining_d = remaining_q;
		data_left_d = data_left_q;
		consumed_d  = consumed_q;
		res_vld     = 1'b0;
		res         = '0;
		if (fire) begin
			if (item_s1.start_req) begin
				if (buf_small) begin
					res_vld          = 1'b1;
					res.result_kind  = cbhp_pkg::KIND_ERROR;
					res.last         = 1'b1;
					res.error_code   = cbhp_pkg::ERR_BUF_SMALL;
				end else begin
					type_d      = item_s1.in_byte;
					flags_d     = '0;
					remaining_d = item_s1.buffer_size - SW'(1);
					consumed_d  = SW'(1);
					data_left_d = '0;
					accum_d     = '0;
					count_d     = '0;
				end
			end else begin
				unique case (phase_q)
					cbhp_pkg::PH_IDLE: begin
						res_vld = 1'b0;
					end
					cbhp_pkg::PH_FLAGS: begin
						if (sdnv_bad) begin
							res_vld         = 1'b1;
							res.result_kind = cbhp_pkg::KIND_ERROR;
							res.last        = 1'b1;
							res.error_code  = cbhp_pkg::ERR_FLAGS_BAD;
						end else begin
							remaining_d = rem_dec;
							consumed_d  = cons_inc;
							if (cont) begin
								accum_d = accum_nx;
								count_d = cnt_inc;
							end else begin
								flags_d = accum_nx;
								accum_d = '0;
								count_d = '0;
								if (rem_dec == '0) begin
									res_vld         = 1'b1;
									res.result_kind = cbhp_pkg::KIND_ERROR;
									res.last        = 1'b1;
									res.error_code  = cbhp_pkg::ERR_LEN_BAD;
								end
							end
						end
					end
					cbhp_pkg::PH_LEN: begin
						if (sdnv_bad) begin
							res_vld         = 1'b1;
							res.result_kind = cbhp_pkg::KIND_ERROR;
							res.last        = 1'b1;
							res.error_code  = cbhp_pkg::ERR_LEN_BAD;
						end else begin
							remaining_d = rem_dec;
							consumed_d  = cons_inc;
							accum_d     = accum_nx;
							count_d     = cnt_inc;
							if (!cont) begin
								res_vld = 1'b1;
								if (len_big) begin
									res.result_kind = cbhp_pkg::KIND_ERROR;
									res.last        = 1'b1;
									res.error_code  = cbhp_pkg::ERR_LEN_BIG;
								end else begin
									data_left_d     = accum_nx[SW-1:0];
									res.result_kind = cbhp_pkg::KIND_HEADER;
									res.block_type  = type_q;
									res.block_flags = flags_q;
									res.data_length = accum_nx[SW-1:0];
									if (accum_nx == '0) begin
										res.last           = 1'b1;
										res.bytes_consumed = cons_inc;
									end
								end
							end
						end
					end
					cbhp_pkg::PH_DATA: begin
						res_vld         = 1'b1;
						res.result_kind = cbhp_pkg::KIND_DATA;
						res.out_byte    = item_s1.in_byte;
						consumed_d      = cons_inc;
						remaining_d     = rem_dec;
						data_left_d     = data_left_q - SW'(1);
						if (data_end) begin
							res.last           = 1'b1;
							res.bytes_consumed = cons_inc;
						end
					end
					default: begin
						res_vld = 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= cbhp_pkg::PH_IDLE;
			type_q      <= '0;
			flags_q     <= '0;
			accum_q     <= '0;
			count_q     <= '0;
			remaining_q <= '0;
			data_left_q <= '0;
			consumed_q  <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= res_vld;
			end
			phase_q     <= phase_d;
			type_q      <= type_d;
			flags_q     <= flags_d;
			accum_q     <= accum_d;
			count_q     <= count_d;
			remaining_q <= remaining_d;
			data_left_q <= data_left_d;
			consumed_q  <= consumed_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_data_q.result_kind == cbhp_pkg::KIND_ERROR) |-> out_data_q.last)
		else $error("error result without last");

	a_code_only_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_data_q.result_kind != cbhp_pkg::KIND_ERROR)
		|-> (out_data_q.error_code == cbhp_pkg::ERR_NONE))
		else $error("error code on a non-error result");

	a_data_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == cbhp_pkg::PH_DATA) |-> (data_left_q != '0))
		else $error("data phase with no data left");

	a_sdnv_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= CntW'(SdnvMaxBytes)))
		else $error("SDNV byte count past its limit");

	a_empty_output_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled while the result register is empty");

endmodule

@@ verif/canonical_block_header_parser_unit_tb.sv @@
// Testbench for the canonical block header parser, checked against a predictor.
`timescale 1ns / 100ps

module canonical_block_header_parser_unit_tb;

	typedef enum int {
		SDNV_MORE,
		SDNV_DONE,
		SDNV_BAD
	} sdnv_step_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	cbhp_pkg::in_item_t  in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	cbhp_pkg::out_item_t out_data;

	logic gaps_on = 1'b1;
	logic stalls_on = 1'b1;
	int   fail_count = 0;

	cbhp_pkg::out_item_t parser_results[$];
	cbhp_pkg::out_item_t oldest_result;
	logic [7:0]          block_bytes[$];

	cbhp_pkg::phase_t p_phase = cbhp_pkg::PH_IDLE;
	logic [7:0]       p_type = '0;
	logic [63:0]      p_flags = '0;
	logic [63:0]      p_accum = '0;
	logic [3:0]       p_count = '0;
	logic [31:0]      p_left = '0;
	logic [31:0]      p_data_left = '0;
	logic [31:0]      p_consumed = '0;

	canonical_block_header_parser_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic cbhp_pkg::out_item_t error_result(cbhp_pkg::error_code_t code);
		cbhp_pkg::out_item_t r;
		r = '0;
		r.result_kind = cbhp_pkg::KIND_ERROR;
		r.last = 1'b1;
		r.error_code = code;
		p_phase = cbhp_pkg::PH_IDLE;
		return r;
	endfunction

	function automatic sdnv_step_t take_group(logic [7:0] b);
		if (p_accum[63:57] != '0) begin
			return SDNV_BAD;
		end
		p_accum = {p_accum[56:0], b[6:0]};
		p_count = p_count + 4'd1;
		p_left = p_left - 32'd1;
		p_consumed = p_consumed + 32'd1;
		if (!b[7]) begin
			return SDNV_DONE;
		end
		if (p_count >= 4'(cbhp_pkg::SDNV_MAX_BYTES) || p_left == '0) begin
			return SDNV_BAD;
		end
		return SDNV_MORE;
	endfunction

	function automatic void parse_byte(cbhp_pkg::in_item_t it);
		cbhp_pkg::out_item_t r;
		sdnv_step_t          s;
		r = '0;
		if (it.start_req) begin
			if (it.buffer_size < 32'd2) begin
				parser_results.push_back(error_result(cbhp_pkg::ERR_BUF_SMALL));
				return;
			end
			p_type = it.in_byte;
			p_flags = '0;
			p_left = it.buffer_size - 32'd1;
			p_consumed = 32'd1;
			p_data_left = '0;
			p_accum = '0;
			p_count = '0;
			p_phase = cbhp_pkg::PH_FLAGS;
			return;
		end
		case (p_phase)
			cbhp_pkg::PH_FLAGS: begin
				s = take_group(it.in_byte);
				if (s == SDNV_BAD) begin
					parser_results.push_back(error_result(cbhp_pkg::ERR_FLAGS_BAD));
				end else if (s == SDNV_DONE) begin
					p_flags = p_accum;
					p_accum = '0;
					p_count = '0;
					if (p_left == '0) begin
						parser_results.push_back(error_result(cbhp_pkg::ERR_LEN_BAD));
					end else begin
						p_phase = cbhp_pkg::PH_LEN;
					end
				end
			end
			cbhp_pkg::PH_LEN: begin
				s = take_group(it.in_byte);
				if (s == SDNV_BAD) begin
					parser_results.push_back(error_result(cbhp_pkg::ERR_LEN_BAD));
				end else if (s == SDNV_DONE) begin
					if (p_accum > {32'd0, p_left}) begin
						parser_results.push_back(error_result(cbhp_pkg::ERR_LEN_BIG));
					end else begin
						p_data_left = p_accum[31:0];
						r.result_kind = cbhp_pkg::KIND_HEADER;
						r.block_type = p_type;
						r.block_flags = p_flags;
						r.data_length = p_data_left;
						if (p_data_left == '0) begin
							r.last = 1'b1;
							r.bytes_consumed = p_consumed;
							p_phase = cbhp_pkg::PH_IDLE;
						end else begin
							p_phase = cbhp_pkg::PH_DATA;
						end
						parser_results.push_back(r);
					end
				end
			end
			cbhp_pkg::PH_DATA: begin
				r.result_kind = cbhp_pkg::KIND_DATA;
				r.out_byte = it.in_byte;
				p_consumed = p_consumed + 32'd1;
				p_left = p_left - 32'd1;
				p_data_left = p_data_left - 32'd1;
				if (p_data_left == '0) begin
					r.last = 1'b1;
					r.bytes_consumed = p_consumed;
					p_phase = cbhp_pkg::PH_IDLE;
				end
				parser_results.push_back(r);
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (parser_results.size() == 0) begin
				$error("result_kind: expected none, actual %0d", out_data.result_kind);
				fail_count++;
			end else begin
				oldest_result = parser_results.pop_front();
				check_field("result_kind", 64'(oldest_result.result_kind),
					64'(out_data.result_kind));
				check_field("block_type", 64'(oldest_result.block_type),
					64'(out_data.block_type));
				check_field("block_flags", oldest_result.block_flags, out_data.block_flags);
				check_field("data_length", 64'(oldest_result.data_length),
					64'(out_data.data_length));
				check_field("out_byte", 64'(oldest_result.out_byte), 64'(out_data.out_byte));
				check_field("last", 64'(oldest_result.last), 64'(out_data.last));
				check_field("bytes_consumed", 64'(oldest_result.bytes_consumed),
					64'(out_data.bytes_consumed));
				check_field("error_code", 64'(oldest_result.error_code),
					64'(out_data.error_code));
			end
		end
		out_ready <= !(stalls_on && $urandom_range(99) < 31);
	end

	task automatic send_byte(logic [7:0] b, logic st, logic [31:0] bufsz);
		cbhp_pkg::in_item_t it;
		it.in_byte = b;
		it.start_req = st;
		it.buffer_size = bufsz;
		while (gaps_on && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do begin
			@(posedge clk);
		end while (!in_ready);
		parse_byte(it);
	endtask

	task automatic start_block(logic [7:0] block_code);
		block_bytes.delete();
		block_bytes.push_back(block_code);
	endtask

	task automatic append_sdnv(logic [63:0] v, int pad);
		int          n;
		int          i;
		logic [63:0] sh;
		n = 1;
		while (n < cbhp_pkg::SDNV_MAX_BYTES && (v >> (7 * n)) != '0) begin
			n++;
		end
		if (pad > cbhp_pkg::SDNV_MAX_BYTES - n) begin
			pad = cbhp_pkg::SDNV_MAX_BYTES - n;
		end
		for (i = 0; i < pad; i++) begin
			block_bytes.push_back(8'h80);
		end
		for (i = n - 1; i >= 0; i--) begin
			sh = v >> (7 * i);
			block_bytes.push_back({i != 0, sh[6:0]});
		end
	endtask

	task automatic append_data(int n);
		int i;
		for (i = 0; i < n; i++) begin
			block_bytes.push_back(8'($urandom_range(255)));
		end
	endtask

	task automatic send_block(logic [31:0] bufsz);
		int i;
		for (i = 0; i < block_bytes.size(); i++) begin
			send_byte(block_bytes[i], i == 0, (i == 0) ? bufsz : 32'($urandom()));
		end
	endtask

	task automatic test_idle_and_small_buffer();
		send_byte(8'hFF, 1'b0, 32'hFFFF_FFFF);
		send_byte(8'h00, 1'b0, 32'h0000_0000);
		send_byte(8'hA5, 1'b1, 32'd0);
		send_byte(8'h5A, 1'b1, 32'd1);
	endtask

	task automatic test_header_extremes();
		start_block(8'hFF);
		append_sdnv(64'hFFFF_FFFF_FFFF_FFFF, 0);
		append_sdnv(64'd2, 0);
		block_bytes.push_back(8'h00);
		block_bytes.push_back(8'hFF);
		send_block(32'(block_bytes.size()));
		start_block(8'h00);
		append_sdnv(64'd0, 0);
		append_sdnv(64'd0, 0);
		send_block(32'd3);
	endtask

	task automatic test_sdnv_errors();
		int i;
		start_block(8'h11);
		block_bytes.push_back(8'h82);
		for (i = 0; i < 8; i++) begin
			block_bytes.push_back(8'hFF);
		end
		block_bytes.push_back(8'h7F);
		send_block(32'd100);
		start_block(8'h22);
		block_bytes.push_back(8'h00);
		for (i = 0; i < cbhp_pkg::SDNV_MAX_BYTES; i++) begin
			block_bytes.push_back(8'h80);
		end
		send_block(32'd100);
		start_block(8'h33);
		block_bytes.push_back(8'h81);
		block_bytes.push_back(8'h81);
		send_block(32'd3);
		start_block(8'h44);
		block_bytes.push_back(8'h05);
		send_block(32'd2);
		start_block(8'h55);
		block_bytes.push_back(8'h00);
		block_bytes.push_back(8'h03);
		send_block(32'd4);
	endtask

	task automatic test_abort_in_progress();
		start_block(8'h66);
		append_sdnv(64'd0, 0);
		append_sdnv(64'd5, 0);
		append_data(1);
		send_block(32'd100);
		start_block(8'h77);
		append_sdnv(64'd0, 0);
		append_sdnv(64'd0, 0);
		send_block(32'd3);
	endtask

	task automatic test_random_blocks(int target);
		int          sent;
		int          pick;
		int          len;
		int          hdr;
		int          total;
		int          keep;
		int          i;
		logic [63:0] flags_v;
		logic [31:0] bufsz;
		sent = 0;
		while (sent < target) begin
			pick = $urandom_range(99);
			if (pick < 85) begin
				flags_v = {32'($urandom()), 32'($urandom())} >> $urandom_range(63);
				if ($urandom_range(9) == 0) begin
					flags_v = '0;
				end
				len = ($urandom_range(99) < 15) ? 0 : $urandom_range(1, 12);
				if (pick >= 78 && len == 0) begin
					len = $urandom_range(1, 12);
				end
				start_block(8'($urandom_range(255)));
				append_sdnv(flags_v, ($urandom_range(99) < 20) ? $urandom_range(1, 9) : 0);
				append_sdnv(64'(len), ($urandom_range(99) < 20) ? $urandom_range(1, 9) : 0);
				hdr = block_bytes.size();
				append_data(len);
				total = block_bytes.size();
				case ($urandom_range(3))
					0, 1: bufsz = 32'(total);
					2: bufsz = 32'(total + $urandom_range(1, 1000));
					default: begin
						bufsz = 32'($urandom());
						if (bufsz < 32'(total)) begin
							bufsz = ($urandom_range(1)) ? 32'hFFFF_FFFF : 32'(total);
						end
					end
				endcase
				if (pick >= 78) begin
					bufsz = 32'(total - $urandom_range(1, len));
				end else if (pick >= 70) begin
					bufsz = 32'($urandom_range(0, hdr - 1));
				end else if (pick >= 62) begin
					keep = $urandom_range(1, total - 1);
					while (block_bytes.size() > keep) begin
						void'(block_bytes.pop_back());
					end
				end
				send_block(bufsz);
				sent += block_bytes.size();
			end else if (pick < 92) begin
				start_block(8'($urandom_range(255)));
				if ($urandom_range(1)) begin
					append_sdnv({32'($urandom()), 32'($urandom())} >> $urandom_range(63), 0);
				end
				block_bytes.push_back(($urandom_range(2) == 0) ?
					8'(8'h80 | $urandom_range(1)) : 8'(8'h80 | $urandom_range(255)));
				for (i = 1; i < cbhp_pkg::SDNV_MAX_BYTES - 1; i++) begin
					block_bytes.push_back(8'(8'h80 | $urandom_range(255)));
				end
				block_bytes.push_back(8'($urandom_range(255)));
				append_data($urandom_range(0, 3));
				send_block(32'($urandom_range(20, 1000)));
				sent += block_bytes.size();
			end else begin
				for (i = $urandom_range(1, 4); i > 0; i--) begin
					send_byte(8'($urandom_range(255)), 1'b0, 32'($urandom()));
				end
				if ($urandom_range(2) == 0) begin
					send_byte(8'($urandom_range(255)), 1'b1, 32'($urandom_range(1)));
					sent++;
				end
			end
		end
	endtask

	task automatic test_back_to_back();
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		test_random_blocks(300);
		gaps_on = 1'b1;
		stalls_on = 1'b1;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_and_small_buffer();
		test_header_extremes();
		test_sdnv_errors();
		test_abort_in_progress();
		test_random_blocks(1100);
		test_back_to_back();
		in_valid <= 1'b0;
		while (parser_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (16) @(posedge clk);
		if (fail_count == 0 && parser_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
